@@ rtl/rsq_pkg.sv @@
// ----------------------------------------------------------------------------
// rsq_pkg
// shared widths, register indexes, channel mode codes and helper functions
// for the resampling requantizer
// ----------------------------------------------------------------------------
package rsq_pkg;

    // sample format
    localparam int SAMPLE_WIDTH = 24;
    localparam int FRAC_W       = SAMPLE_WIDTH - 1;
    localparam int MAX_REPEATS  = 8;

    // configuration register widths
    localparam int STEP_W     = 21;
    localparam int QBITS_W    = 5;
    localparam int MODE_W     = 2;
    localparam int GAIN_W     = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 21;

    // quantizer
    localparam int QB_MAX     = 24;
    localparam int GAIN_UNITY = 100;

    // phase accumulator, 5.16
    localparam int PHASE_W    = 21;
    localparam int PHASE_FRAC = 16;
    localparam int PHASE_ONE  = 65536;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_STEP_RATIO   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_QUANT_BITS   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_MODE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_LEFT    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_RIGHT   = 3'd4;

    // register reset values
    localparam logic [STEP_W-1:0]  STEP_RESET  = STEP_W'(65536);
    localparam logic [QBITS_W-1:0] QBITS_RESET = QBITS_W'(16);
    localparam logic [GAIN_W-1:0]  GAIN_RESET  = GAIN_W'(GAIN_UNITY);

    // channel modes
    localparam logic [MODE_W-1:0] MODE_MONO        = 2'd0;
    localparam logic [MODE_W-1:0] MODE_MONO_STEREO = 2'd1;
    localparam logic [MODE_W-1:0] MODE_STEREO      = 2'd2;
    localparam logic [MODE_W-1:0] MODE_STEREO_MONO = 2'd3;
    localparam logic [MODE_W-1:0] MODE_RESET       = MODE_STEREO;

    // lane datapath widths
    localparam int P1_W = SAMPLE_WIDTH + QB_MAX;     // sample * levels
    localparam int P2_W = P1_W + 9;                  // times gain
    localparam int Y_W  = SAMPLE_WIDTH + 2;          // rescaled sample
    localparam int SUM_W = Y_W + 1;                  // sum of two lanes

    // iterative divider
    localparam int DIV_STEP   = 3;
    localparam int DIV_D_W    = (SAMPLE_WIDTH + 6 > QB_MAX) ? SAMPLE_WIDTH + 6 : QB_MAX;
    localparam int DIV_Q_RAW  = (QB_MAX + 3 > SAMPLE_WIDTH + 2) ? QB_MAX + 3 : SAMPLE_WIDTH + 2;
    localparam int DIV_CYCLES = (DIV_Q_RAW + DIV_STEP - 1) / DIV_STEP;
    localparam int DIV_Q_W    = DIV_CYCLES * DIV_STEP;
    localparam int DIV_N_W    = DIV_D_W + DIV_Q_W;
    localparam int DIV_CNT_W  = $clog2(DIV_CYCLES);

    // percent scale 100 * 2^frac as divisor
    localparam logic [DIV_D_W-1:0] PCT_SCALE = DIV_D_W'(GAIN_UNITY) << FRAC_W;

    // repeat counter
    localparam int RPT_W = (MAX_REPEATS > 1) ? $clog2(MAX_REPEATS) : 1;

    typedef struct packed {
        logic                            start;
        logic signed [SAMPLE_WIDTH-1:0]  sample;
        logic [GAIN_W-1:0]               gain;
        logic [QB_MAX-1:0]               levels;
    } lane_req_t;

    // 2^b - 1 with b clamped to 1..QB_MAX
    function automatic logic [QB_MAX-1:0] levels_for(input logic [QBITS_W-1:0] bits);
        logic [QBITS_W-1:0] b;
        b = bits;
        if (b == '0) begin
            b = QBITS_W'(1);
        end else if (b > QBITS_W'(QB_MAX)) begin
            b = QBITS_W'(QB_MAX);
        end
        return ~({QB_MAX{1'b1}} << b);
    endfunction

    // clamp to the signed sample range
    function automatic logic signed [SAMPLE_WIDTH-1:0] sat_sample(
        input logic signed [SUM_W-1:0] v
    );
        logic [SUM_W-SAMPLE_WIDTH:0] top;
        top = v[SUM_W-1:SAMPLE_WIDTH-1];
        if (top == '0 || top == '1) begin
            return v[SAMPLE_WIDTH-1:0];
        end else if (v[SUM_W-1]) begin
            return {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
        end else begin
            return {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
        end
    endfunction

endpackage

@@ rtl/rsq_div.sv @@
// ----------------------------------------------------------------------------
// rsq_div
// unsigned restoring divider, DIV_STEP quotient bits per cycle
// ----------------------------------------------------------------------------
module rsq_div
    import rsq_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic [DIV_N_W-1:0]   dividend,
    input  logic [DIV_D_W-1:0]   divisor,
    output logic                 done,
    output logic [DIV_Q_W-1:0]   quotient
);

    logic [DIV_D_W-1:0]   rem_reg;
    logic [DIV_D_W-1:0]   rem_next;
    logic [DIV_Q_W-1:0]   acc_reg;
    logic [DIV_Q_W-1:0]   acc_next;
    logic [DIV_D_W-1:0]   dsr_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;

    // dividend bits leave acc at the top while quotient bits enter at the bottom
    always_comb begin
        logic [DIV_D_W:0] trial;
        logic             qbit;
        rem_next = rem_reg;
        acc_next = acc_reg;
        for (int i = 0; i < DIV_STEP; i++) begin
            trial = {rem_next, acc_next[DIV_Q_W-1]};
            if (trial >= {1'b0, dsr_reg}) begin
                trial = trial - {1'b0, dsr_reg};
                qbit  = 1'b1;
            end else begin
                qbit  = 1'b0;
            end
            rem_next = trial[DIV_D_W-1:0];
            acc_next = {acc_next[DIV_Q_W-2:0], qbit};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(DIV_CYCLES - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= dividend[DIV_N_W-1 -: DIV_D_W];
            acc_reg <= dividend[DIV_Q_W-1:0];
            dsr_reg <= divisor;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            acc_reg <= acc_next;
        end
    end

    assign done     = done_reg;
    assign quotient = acc_reg;

endmodule

@@ rtl/rsq_lane.sv @@
// ----------------------------------------------------------------------------
// rsq_lane
// one requantizer lane: scale by levels and gain, floor divide by the
// percent scale, then rescale by floor divide by the level count
// ----------------------------------------------------------------------------
module rsq_lane
    import rsq_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  lane_req_t             req,
    output logic                  done,
    output logic signed [Y_W-1:0] y
);

    localparam logic [2:0] L_IDLE      = 3'd0;
    localparam logic [2:0] L_MUL1      = 3'd1;
    localparam logic [2:0] L_MUL2      = 3'd2;
    localparam logic [2:0] L_DIV1_GO   = 3'd3;
    localparam logic [2:0] L_DIV1_WAIT = 3'd4;
    localparam logic [2:0] L_DIV2_GO   = 3'd5;
    localparam logic [2:0] L_DIV2_WAIT = 3'd6;

    logic [2:0]                     state_reg;
    logic [2:0]                     state_next;
    logic signed [SAMPLE_WIDTH-1:0] x_reg;
    logic [GAIN_W-1:0]              gain_reg;
    logic [QB_MAX-1:0]              levels_reg;
    logic signed [P1_W-1:0]         p1_reg;
    logic signed [P2_W-1:0]         p2_reg;
    logic                           neg_reg;
    logic signed [Y_W-1:0]          y_reg;
    logic                           done_reg;

    logic                           div_start;
    logic [DIV_N_W-1:0]             div_dividend;
    logic [DIV_D_W-1:0]             div_divisor;
    logic                           div_done;
    logic [DIV_Q_W-1:0]             div_quo;
    logic [DIV_N_W-1:0]             p2_ext;
    logic [QB_MAX-1:0]              levels_m1;
    logic [Y_W-1:0]                 y_mag;

    assign p2_ext    = DIV_N_W'(p2_reg);
    assign levels_m1 = {levels_reg[QB_MAX-1:1], 1'b0};
    assign y_mag     = Y_W'(div_quo);

    // floor for a negative numerator: divide |n| + d - 1, then negate
    always_comb begin
        div_start    = 1'b0;
        div_dividend = p2_ext;
        div_divisor  = PCT_SCALE;
        case (state_reg)
            L_DIV1_GO: begin
                div_start = 1'b1;
                if (p2_reg[P2_W-1]) begin
                    div_dividend = DIV_N_W'(PCT_SCALE) + ~p2_ext;
                end
            end
            L_DIV2_GO: begin
                div_start    = 1'b1;
                div_divisor  = DIV_D_W'(levels_reg);
                div_dividend = (DIV_N_W'(div_quo) << FRAC_W)
                             + (neg_reg ? DIV_N_W'(levels_m1) : '0);
            end
            L_DIV2_WAIT: begin
                div_divisor = DIV_D_W'(levels_reg);
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            L_IDLE:      if (req.start) state_next = L_MUL1;
            L_MUL1:      state_next = L_MUL2;
            L_MUL2:      state_next = L_DIV1_GO;
            L_DIV1_GO:   state_next = L_DIV1_WAIT;
            L_DIV1_WAIT: if (div_done) state_next = L_DIV2_GO;
            L_DIV2_GO:   state_next = L_DIV2_WAIT;
            L_DIV2_WAIT: if (div_done) state_next = L_IDLE;
            default:     state_next = L_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= L_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= (state_reg == L_DIV2_WAIT) && div_done;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == L_IDLE && req.start) begin
            x_reg      <= req.sample;
            gain_reg   <= req.gain;
            levels_reg <= req.levels;
        end
        if (state_reg == L_MUL1) begin
            p1_reg <= P1_W'(x_reg) * P1_W'($signed({1'b0, levels_reg}));
        end
        if (state_reg == L_MUL2) begin
            p2_reg <= P2_W'(p1_reg) * P2_W'($signed({1'b0, gain_reg}));
        end
        if (state_reg == L_DIV1_GO) begin
            neg_reg <= p2_reg[P2_W-1];
        end
        if (state_reg == L_DIV2_WAIT && div_done) begin
            y_reg <= neg_reg ? -$signed(y_mag) : $signed(y_mag);
        end
    end

    rsq_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign done = done_reg;
    assign y    = y_reg;

endmodule

@@ rtl/rsq_merge.sv @@
// ----------------------------------------------------------------------------
// rsq_merge
// combines the two lane results by channel mode and saturates
// ----------------------------------------------------------------------------
module rsq_merge
    import rsq_pkg::*;
(
    input  logic                           aclk,
    input  logic                           load,
    input  logic [MODE_W-1:0]              mode,
    input  logic signed [Y_W-1:0]          y_left,
    input  logic signed [Y_W-1:0]          y_right,
    output logic signed [SAMPLE_WIDTH-1:0] out_left,
    output logic signed [SAMPLE_WIDTH-1:0] out_right
);

    logic signed [SAMPLE_WIDTH-1:0] left_reg;
    logic signed [SAMPLE_WIDTH-1:0] right_reg;
    logic signed [SAMPLE_WIDTH-1:0] left_next;
    logic signed [SAMPLE_WIDTH-1:0] right_next;
    logic signed [SUM_W-1:0]        sum;

    assign sum = SUM_W'(y_left) + SUM_W'(y_right);

    always_comb begin
        left_next  = sat_sample(SUM_W'(y_left));
        right_next = '0;
        case (mode)
            MODE_MONO: begin
            end
            MODE_MONO_STEREO, MODE_STEREO: begin
                right_next = sat_sample(SUM_W'(y_right));
            end
            MODE_STEREO_MONO: begin
                left_next = sat_sample(sum);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            left_reg  <= left_next;
            right_reg <= right_next;
        end
    end

    assign out_left  = left_reg;
    assign out_right = right_reg;

endmodule

@@ rtl/resample_requantize.sv @@
// ----------------------------------------------------------------------------
// resample_requantize
// nearest-neighbor drop/repeat rate converter with bit-depth reduction
// ----------------------------------------------------------------------------
// each input transaction carries one stereo frame of Q1.23 samples. a 5.16
// phase accumulator stepped by step_ratio decides how many output
// transactions the frame produces: none when the phase is at or above one
// (the frame is dropped and the phase lowered by one), otherwise one per
// step until the phase reaches one, at most MAX_REPEATS. every copy carries
// the same pair of requantized samples, and last_of_run marks the final
// copy of a frame. two lanes requantize the left and right paths side by
// side; each lane runs two multiplies and then two floor divisions through
// its own divider that retires 3 quotient bits per cycle. the block works on
// one frame at a time and holds each result until it is accepted.
// configuration writes take effect at once and must only happen while the
// block is idle.
// ----------------------------------------------------------------------------
module resample_requantize
    import rsq_pkg::*;
(
    input  logic                           aclk,
    input  logic                           aresetn,

    // configuration write port
    input  logic                           cfg_we,
    input  logic [CFG_IDX_W-1:0]           cfg_index,
    input  logic [CFG_DATA_W-1:0]          cfg_wdata,

    // input frames
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic signed [SAMPLE_WIDTH-1:0] s_left_sample,
    input  logic signed [SAMPLE_WIDTH-1:0] s_right_sample,

    // output samples
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic signed [SAMPLE_WIDTH-1:0] m_out_left,
    output logic signed [SAMPLE_WIDTH-1:0] m_out_right,
    output logic                           m_last_of_run
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CALC = 2'd1;
    localparam logic [1:0] S_EMIT = 2'd2;

    // configuration registers
    logic [STEP_W-1:0]  step_ratio_reg;
    logic [QBITS_W-1:0] quant_bits_reg;
    logic [MODE_W-1:0]  channel_mode_reg;
    logic [GAIN_W-1:0]  gain_left_reg;
    logic [GAIN_W-1:0]  gain_right_reg;

    // control state
    logic [1:0]            state_reg;
    logic [1:0]            state_next;
    logic [PHASE_W-1:0]    phase_reg;
    logic [PHASE_W-1:0]    phase_next;
    logic [PHASE_FRAC-1:0] ph_work_reg;
    logic [RPT_W-1:0]      cnt_reg;

    logic                  s_take;
    logic                  m_take;
    logic                  phase_high;
    logic                  frame_go;
    logic [STEP_W:0]       ph_sum;
    logic                  run_over;
    logic                  cap_hit;
    logic                  last_now;

    lane_req_t             lane_req [2];
    logic [1:0]            lane_done;
    logic signed [Y_W-1:0] lane_y [2];
    logic [QB_MAX-1:0]     levels;

    // ---------------------------------------------------------------- handshake
    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = (state_reg == S_EMIT);
    assign s_take  = s_valid && s_ready;
    assign m_take  = m_valid && m_ready;

    // ------------------------------------------------------------ configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_ratio_reg   <= STEP_RESET;
            quant_bits_reg   <= QBITS_RESET;
            channel_mode_reg <= MODE_RESET;
            gain_left_reg    <= GAIN_RESET;
            gain_right_reg   <= GAIN_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_STEP_RATIO:   step_ratio_reg   <= cfg_wdata[STEP_W-1:0];
                REG_QUANT_BITS:   quant_bits_reg   <= cfg_wdata[QBITS_W-1:0];
                REG_CHANNEL_MODE: channel_mode_reg <= cfg_wdata[MODE_W-1:0];
                REG_GAIN_LEFT:    gain_left_reg    <= cfg_wdata[GAIN_W-1:0];
                REG_GAIN_RIGHT:   gain_right_reg   <= cfg_wdata[GAIN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------- phase
    // a frame arriving with phase at or above one is dropped on the spot
    assign phase_high = (phase_reg >= PHASE_W'(PHASE_ONE));
    assign frame_go   = s_take && !phase_high;

    // phase after the current copy; the run ends once it reaches one or the repeat cap is hit
    assign ph_sum   = (STEP_W + 1)'(ph_work_reg) + (STEP_W + 1)'(step_ratio_reg);
    assign run_over = (ph_sum >= (STEP_W + 1)'(PHASE_ONE));
    assign cap_hit  = (cnt_reg == RPT_W'(MAX_REPEATS - 1));
    assign last_now = run_over || cap_hit;

    always_comb begin
        phase_next = phase_reg;
        if (s_take && phase_high) begin
            phase_next = phase_reg - PHASE_W'(PHASE_ONE);
        end else if (m_take && last_now) begin
            // stopped by the repeat cap below one: restart the phase at zero
            phase_next = run_over ? PHASE_W'(ph_sum - (STEP_W + 1)'(PHASE_ONE)) : '0;
        end
    end

    // ------------------------------------------------------------- sequencing
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: if (frame_go) state_next = S_CALC;
            S_CALC: if (lane_done[0]) state_next = S_EMIT;
            S_EMIT: if (m_take && last_now) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            phase_reg   <= '0;
            ph_work_reg <= '0;
            cnt_reg     <= '0;
        end else begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            if (frame_go) begin
                ph_work_reg <= phase_reg[PHASE_FRAC-1:0];
                cnt_reg     <= '0;
            end else if (m_take && !last_now) begin
                ph_work_reg <= ph_sum[PHASE_FRAC-1:0];
                cnt_reg     <= cnt_reg + 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------ lanes
    // lane 0 carries the left or mono path, lane 1 the right path; in
    // mono-to-stereo both lanes take the left sample with their own gains
    assign levels = levels_for(quant_bits_reg);

    always_comb begin
        lane_req[0].start  = frame_go;
        lane_req[0].sample = s_left_sample;
        lane_req[0].levels = levels;
        lane_req[0].gain   = (channel_mode_reg == MODE_MONO ||
                              channel_mode_reg == MODE_STEREO)
                           ? GAIN_W'(GAIN_UNITY) : gain_left_reg;

        lane_req[1].start  = frame_go;
        lane_req[1].sample = (channel_mode_reg == MODE_MONO_STEREO)
                           ? s_left_sample : s_right_sample;
        lane_req[1].levels = levels;
        lane_req[1].gain   = (channel_mode_reg == MODE_STEREO)
                           ? GAIN_W'(GAIN_UNITY) : gain_right_reg;
    end

    for (genvar g = 0; g < 2; g++) begin : g_lane
        rsq_lane u_lane (
            .aclk    (aclk),
            .aresetn (aresetn),
            .req     (lane_req[g]),
            .done    (lane_done[g]),
            .y       (lane_y[g])
        );
    end

    // merge the lane results into the output register
    rsq_merge u_merge (
        .aclk      (aclk),
        .load      ((state_reg == S_CALC) && lane_done[0]),
        .mode      (channel_mode_reg),
        .y_left    (lane_y[0]),
        .y_right   (lane_y[1]),
        .out_left  (m_out_left),
        .out_right (m_out_right)
    );

    assign m_last_of_run = last_now;

`ifndef SYNTH
    // both lanes have a fixed, equal latency
    a_lanes_in_step: assert property (@(posedge aclk) disable iff (!aresetn)
        lane_done[0] == lane_done[1])
        else $error("lane completion out of step");

    // one frame at a time: never taking a frame while results are pending
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input ready while results pending");

    // a result not marked last is followed by another result
    a_run_continues: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !m_last_of_run) |=> m_valid)
        else $error("run ended without last_of_run");

    // the last result of a run frees the input side
    a_run_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_last_of_run) |=> (s_ready && !m_valid))
        else $error("block not idle after last_of_run");
`endif

endmodule
